// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define TDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tds check failed: same-cycle rule");

// Next-cycle implication, masked while reset is asserted
`define TDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tds check failed: next-cycle rule");

// Next-cycle implication that also holds across reset
`define TDS_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tds check failed: reset rule");

`endif

// ===== rtl/tds_pkg.sv =====
// ----------------------------------------------------------------------------
// tds_pkg
// Widths, constants, datapath commands and status for the TDS converter.
// ----------------------------------------------------------------------------
package tds_pkg;

    // Field and register widths
    localparam int VOLT_W     = 16;
    localparam int KNOWN_W    = 20;
    localparam int TDS_W      = 20;
    localparam int K_W        = 16;
    localparam int TEMP_W     = 15;
    localparam int GAIN_W     = 16;
    localparam int BIAS_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WATER_TEMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_BIAS   = 2'd2;

    // Register reset values
    localparam logic [TEMP_W-1:0] TEMP_RESET = 15'd6400;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
    localparam logic [BIAS_W-1:0] BIAS_RESET = 20'd0;
    localparam logic [K_W-1:0]    K_ONE      = 16'd4096;
    localparam logic [K_W-1:0]    K_MAX      = 16'hFFFF;
    localparam logic [TDS_W-1:0]  TDS_MAX    = 20'hFFFFF;

    // Internal widths of the conversion
    localparam int TEMP_D_W = 16;   // 6400 + temperature
    localparam int CV_W     = 16;   // compensated volts, Q.12
    localparam int C2_W     = 32;   // cv squared
    localparam int T2_W     = 31;   // 25586 * cv
    localparam int Q_W      = 46;   // quadratic factor of the cubic
    localparam int Q_SUM_W  = Q_W + 1;
    localparam int P_W      = 62;   // cv * Q
    localparam int P_HI_LSB = 32;
    localparam int RAW_W    = 23;   // raw TDS, Q19.4
    localparam int MK_W     = RAW_W + K_W;
    localparam int MG_W     = MK_W + GAIN_W;
    localparam int MEAS_SH  = 24;
    localparam int S_W      = MG_W + 2;

    // Shared multiplier
    localparam int MUL_AW = 48;
    localparam int MUL_BW = 16;
    localparam int PROD_W = MUL_AW + MUL_BW;

    // Shared divider: two quotient bits per cycle
    localparam int DIV_NW           = 34;
    localparam int DIV_DW           = 23;
    localparam int DIV_BITS_PER_CYC = 2;
    localparam int DIV_STEPS        = DIV_NW / DIV_BITS_PER_CYC;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS + 1);

    // Cubic coefficients scaled by 100, temperature and rounding constants
    localparam int C_TEMP_BASE = 6400;
    localparam int C_A3        = 13342;
    localparam int C_A2        = 25586;
    localparam int C_A1        = 85739;
    localparam int C_RAW_DEN   = 100;
    localparam int C_RAW_HALF  = 50;
    localparam int C_KQ_SH     = 12;
    localparam logic [Q_SUM_W-1:0] C_LIN_TERM = Q_SUM_W'(C_A1) << MEAS_SH;
    localparam logic [S_W-1:0]     C_ROUND_S  = S_W'(1) << (MEAS_SH - 1);

    // Operation codes of an input word
    localparam logic OPER_MEASURE   = 1'b0;
    localparam logic OPER_CALIBRATE = 1'b1;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_CV,
        OP_M25,
        OP_SQ,
        OP_M13,
        OP_QSUM,
        OP_MP,
        OP_DIV_RAW,
        OP_MK,
        OP_MG,
        OP_FIN_MEAS,
        OP_DIV_K,
        OP_FIN_CAL,
        OP_FIN_ZERO
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic is_cal;
        logic q_zero;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/tds_in_if.sv =====
// ----------------------------------------------------------------------------
// tds_in_if
// Input word channel: operation, probe voltage and reference ppm.
// ----------------------------------------------------------------------------
interface tds_in_if import tds_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [VOLT_W-1:0]  probe_volts;
    logic [KNOWN_W-1:0] known_ppm;

    modport source (output valid, output operation, output probe_volts,
                    output known_ppm, input ready);
    modport sink   (input valid, input operation, input probe_volts,
                    input known_ppm, output ready);
endinterface

// ===== rtl/tds_out_if.sv =====
// ----------------------------------------------------------------------------
// tds_out_if
// Result word channel: TDS value, k factor and flags.
// ----------------------------------------------------------------------------
interface tds_out_if import tds_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TDS_W-1:0] tds_ppm;
    logic [K_W-1:0]   k_now;
    logic             k_changed;
    logic             saturated;

    modport source (output valid, output tds_ppm, output k_now, output k_changed,
                    output saturated, input ready);
    modport sink   (input valid, input tds_ppm, input k_now, input k_changed,
                    input saturated, output ready);
endinterface

// ===== rtl/tds_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tds_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tds_cfg_if import tds_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tds_div.sv =====
// ----------------------------------------------------------------------------
// tds_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tds_div import tds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_busy,
    output logic [DIV_NW-1:0] o_quo
);
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DW-1:0]    r_rem;
    logic [DIV_DW-1:0]    n_rem;
    logic [DIV_NW-1:0]    r_quo;
    logic [DIV_NW-1:0]    n_quo;
    logic [DIV_DW-1:0]    r_den;
    logic [DIV_DW:0]      trial;

    // Two restoring steps: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int j = 0; j < DIV_BITS_PER_CYC; j++) begin
            trial = {n_rem, n_quo[DIV_NW-1]};
            n_quo = {n_quo[DIV_NW-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial    = trial - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[DIV_DW-1:0];
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    // Dividend shifts out as the quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
endmodule

// ===== rtl/tds_dp.sv =====
// ----------------------------------------------------------------------------
// tds_dp
// Datapath: configuration registers, k factor, shared multiplier, divider
// and the output register.
// ----------------------------------------------------------------------------
module tds_dp import tds_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_operation,
    input  logic [VOLT_W-1:0]     i_probe_volts,
    input  logic [KNOWN_W-1:0]    i_known_ppm,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [TDS_W-1:0]      o_tds_ppm,
    output logic [K_W-1:0]        o_k_now,
    output logic                  o_k_changed,
    output logic                  o_saturated
);
    // Configuration and state
    logic [TEMP_W-1:0]   r_water_temp;
    logic [GAIN_W-1:0]   r_cal_gain;
    logic [BIAS_W-1:0]   r_cal_bias;
    logic [K_W-1:0]      r_k;

    // Item and working registers
    logic                r_op;
    logic [VOLT_W-1:0]   r_volts;
    logic [KNOWN_W-1:0]  r_known;
    logic [CV_W-1:0]     r_cv;
    logic [C2_W-1:0]     r_c2;
    logic [T2_W-1:0]     r_t2;
    logic [Q_W-1:0]      r_q;
    logic [PROD_W-1:0]   r_prod;

    // Output register
    logic                r_out_valid;
    logic [TDS_W-1:0]    r_tds;
    logic                r_k_changed;
    logic                r_sat;

    // Combinational helpers
    logic [MUL_AW-1:0]   mul_a;
    logic [MUL_BW-1:0]   mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic                div_start;
    logic [DIV_NW-1:0]   div_num;
    logic [DIV_DW-1:0]   div_den;
    logic                div_busy;
    logic [DIV_NW-1:0]   div_quo;
    logic [TEMP_D_W-1:0] temp_den;
    logic [Q_SUM_W-1:0]  q_sum;
    logic [S_W-1:0]      bias_ext;
    logic [S_W-1:0]      meas_sum;
    logic                meas_neg;
    logic                meas_ovf;
    logic                k_ovf;
    logic                out_free;

    // Compensation denominator: 6400 + temperature
    assign temp_den = TEMP_D_W'(C_TEMP_BASE) + TEMP_D_W'(r_water_temp);

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_M25: begin
                mul_a = MUL_AW'(div_quo[CV_W-1:0]);
                mul_b = MUL_BW'(C_A2);
            end
            OP_SQ: begin
                mul_a = MUL_AW'(r_cv);
                mul_b = r_cv;
            end
            OP_M13: begin
                mul_a = MUL_AW'(r_c2);
                mul_b = MUL_BW'(C_A3);
            end
            OP_MP: begin
                mul_a = MUL_AW'(r_q);
                mul_b = r_cv;
            end
            OP_MK: begin
                mul_a = MUL_AW'(div_quo[RAW_W-1:0]);
                mul_b = r_k;
            end
            OP_MG: begin
                mul_a = MUL_AW'(r_prod[MK_W-1:0]);
                mul_b = r_cal_gain;
            end
            default: begin
            end
        endcase
    end

    assign mul_p = {{MUL_BW{1'b0}}, mul_a} * {{MUL_AW{1'b0}}, mul_b};

    // Divider operand select
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (i_cmd.op)
            OP_DIV_CV: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(r_volts) * DIV_NW'(C_TEMP_BASE)
                          + DIV_NW'(temp_den >> 1);
                div_den   = DIV_DW'(temp_den);
            end
            OP_DIV_RAW: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(r_prod[P_W-1:P_HI_LSB]) + DIV_NW'(C_RAW_HALF);
                div_den   = DIV_DW'(C_RAW_DEN);
            end
            OP_DIV_K: begin
                div_start = 1'b1;
                div_num   = DIV_NW'({r_known, {C_KQ_SH{1'b0}}})
                          + DIV_NW'(div_quo[RAW_W-1:1]);
                div_den   = div_quo[DIV_DW-1:0];
            end
            default: begin
            end
        endcase
    end

    tds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // Quadratic factor: 13342*cv^2 + 85739*2^24 - 25586*cv*2^12, never negative
    assign q_sum = Q_SUM_W'(r_prod[Q_W-1:0]) + C_LIN_TERM
                 - Q_SUM_W'({r_t2, {C_KQ_SH{1'b0}}});

    // Measure result: scaled raw plus bias, rounded, then range check
    assign bias_ext = {{(S_W - BIAS_W - MEAS_SH){r_cal_bias[BIAS_W-1]}},
                       r_cal_bias, {MEAS_SH{1'b0}}};
    assign meas_sum = S_W'(r_prod[MG_W-1:0]) + bias_ext + C_ROUND_S;
    assign meas_neg = meas_sum[S_W-1];
    assign meas_ovf = |meas_sum[S_W-2:MEAS_SH+TDS_W];

    // Calibrated k above full scale
    assign k_ovf = |div_quo[DIV_NW-1:K_W];

    assign out_free = !r_out_valid || i_out_ready;

    // Configuration, k factor and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_water_temp <= TEMP_RESET;
            r_cal_gain   <= GAIN_RESET;
            r_cal_bias   <= BIAS_RESET;
            r_k          <= K_ONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_WATER_TEMP: r_water_temp <= i_cfg_data[TEMP_W-1:0];
                    CFG_CAL_GAIN:   r_cal_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_CAL_BIAS:   r_cal_bias   <= i_cfg_data[BIAS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == OP_FIN_CAL) begin
                r_k <= k_ovf ? K_MAX : div_quo[K_W-1:0];
            end
            if (i_cmd.op == OP_FIN_MEAS || i_cmd.op == OP_FIN_CAL ||
                i_cmd.op == OP_FIN_ZERO) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_op    <= i_operation;
                r_volts <= i_probe_volts;
                r_known <= i_known_ppm;
            end
            OP_M25: begin
                r_cv <= div_quo[CV_W-1:0];
                r_t2 <= mul_p[T2_W-1:0];
            end
            OP_SQ:   r_c2   <= mul_p[C2_W-1:0];
            OP_M13:  r_prod <= mul_p;
            OP_QSUM: r_q    <= q_sum[Q_W-1:0];
            OP_MP:   r_prod <= mul_p;
            OP_MK:   r_prod <= mul_p;
            OP_MG:   r_prod <= mul_p;
            OP_FIN_MEAS: begin
                r_k_changed <= 1'b0;
                if (meas_neg) begin
                    r_tds <= '0;
                    r_sat <= 1'b1;
                end else if (meas_ovf) begin
                    r_tds <= TDS_MAX;
                    r_sat <= 1'b1;
                end else begin
                    r_tds <= meas_sum[MEAS_SH+TDS_W-1:MEAS_SH];
                    r_sat <= 1'b0;
                end
            end
            OP_FIN_CAL: begin
                r_tds       <= '0;
                r_k_changed <= 1'b1;
                r_sat       <= k_ovf;
            end
            OP_FIN_ZERO: begin
                r_tds       <= '0;
                r_k_changed <= 1'b0;
                r_sat       <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Status back to the controller
    always_comb begin
        o_sts.div_busy = div_busy;
        o_sts.is_cal   = (r_op == OPER_CALIBRATE);
        o_sts.q_zero   = (div_quo == '0);
        o_sts.out_free = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_tds_ppm   = r_tds;
    assign o_k_now     = r_k;
    assign o_k_changed = r_k_changed;
    assign o_saturated = r_sat;
endmodule

// ===== rtl/tds_ctrl.sv =====
// ----------------------------------------------------------------------------
// tds_ctrl
// Sequencer: steps the datapath through one conversion per input word.
// ----------------------------------------------------------------------------
module tds_ctrl import tds_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_DIVCV  = 17'h00002,
        S_WCV    = 17'h00004,
        S_M25    = 17'h00008,
        S_SQ     = 17'h00010,
        S_M13    = 17'h00020,
        S_QSUM   = 17'h00040,
        S_MP     = 17'h00080,
        S_DIVRAW = 17'h00100,
        S_WRAW   = 17'h00200,
        S_MK     = 17'h00400,
        S_MG     = 17'h00800,
        S_FINM   = 17'h01000,
        S_DIVK   = 17'h02000,
        S_WK     = 17'h04000,
        S_FINC   = 17'h08000,
        S_FINZ   = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DIVCV;
                end
            end
            S_DIVCV: begin
                o_cmd.op = OP_DIV_CV;
                n_state  = S_WCV;
            end
            S_WCV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_M25;
                end
            end
            S_M25: begin
                o_cmd.op = OP_M25;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_M13;
            end
            S_M13: begin
                o_cmd.op = OP_M13;
                n_state  = S_QSUM;
            end
            S_QSUM: begin
                o_cmd.op = OP_QSUM;
                n_state  = S_MP;
            end
            S_MP: begin
                o_cmd.op = OP_MP;
                n_state  = S_DIVRAW;
            end
            S_DIVRAW: begin
                o_cmd.op = OP_DIV_RAW;
                n_state  = S_WRAW;
            end
            S_WRAW: begin
                if (!i_sts.div_busy) begin
                    if (!i_sts.is_cal) begin
                        n_state = S_MK;
                    end else if (i_sts.q_zero) begin
                        n_state = S_FINZ;
                    end else begin
                        n_state = S_DIVK;
                    end
                end
            end
            S_MK: begin
                o_cmd.op = OP_MK;
                n_state  = S_MG;
            end
            S_MG: begin
                o_cmd.op = OP_MG;
                n_state  = S_FINM;
            end
            S_FINM: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_FIN_MEAS;
                    n_state  = S_IDLE;
                end
            end
            S_DIVK: begin
                o_cmd.op = OP_DIV_K;
                n_state  = S_WK;
            end
            S_WK: begin
                if (!i_sts.div_busy) begin
                    n_state = S_FINC;
                end
            end
            S_FINC: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_FIN_CAL;
                    n_state  = S_IDLE;
                end
            end
            S_FINZ: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_FIN_ZERO;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/tds_voltage_to_ppm_top.sv =====
// ----------------------------------------------------------------------------
// tds_voltage_to_ppm_top
// Flow: measure and calibrate words share the conversion to a raw value; a
//   calibrate word skips the k division when the raw value rounds to zero.
// Throughput: one word at a time; the next word is accepted once the result
//   is loaded. Set by the passes of the shared divider.
// Reset: synchronous, active low; k factor returns to 1.0, registers to
//   their defaults, pending result dropped.
// ----------------------------------------------------------------------------
module tds_voltage_to_ppm_top import tds_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    tds_in_if.sink    i_in,
    tds_cfg_if.sink   i_cfg,
    tds_out_if.source o_out
);
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    tds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tds_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_operation   (i_in.operation),
        .i_probe_volts (i_in.probe_volts),
        .i_known_ppm   (i_in.known_ppm),
        .i_cfg_wr      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_tds_ppm     (o_out.tds_ppm),
        .o_k_now       (o_out.k_now),
        .o_k_changed   (o_out.k_changed),
        .o_saturated   (o_out.saturated)
    );

    // Input side follows the sequencer; register writes are always taken
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
endmodule

// ===== rtl/tds_chk.sv =====
// ----------------------------------------------------------------------------
// tds_chk
// Port-level checks of the TDS converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tds_chk import tds_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [TDS_W-1:0] i_tds_ppm,
    input logic [K_W-1:0]   i_k_now,
    input logic             i_k_changed
);
    // One word in flight: after an accept the input side closes
    `TDS_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A calibrate word that wrote k reports zero ppm
    `TDS_ASSERT_IMP(a_cal_zero_ppm, i_clk, i_rst_n, i_out_valid && i_k_changed, i_tds_ppm == '0)

    // A stalled result word holds
    `TDS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_tds_ppm) && $stable(i_k_now))

    // Reset leaves no result and an open input side
    `TDS_ASSERT_RST(a_reset_state, i_clk, !i_rst_n, !i_out_valid && i_in_ready)
endmodule

bind tds_voltage_to_ppm_top tds_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_tds_ppm   (o_out.tds_ppm),
    .i_k_now     (o_out.k_now),
    .i_k_changed (o_out.k_changed)
);
